### rtl/ad2i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ad2i_pkg
// Shared types and constants for the ASCII decimal to integer converter.
// ----------------------------------------------------------------------------
package ad2i_pkg;

   // Width of the parsed magnitude (8 to 64).
   localparam int VALUE_WIDTH = 64;
   // Room for magnitude * 10 + 9 without loss.
   localparam int WIDE_WIDTH  = VALUE_WIDTH + 4;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } ad2i_req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        is_negative;
      logic        ok;
   } ad2i_rsp_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] acc;
      logic                   started;
      logic                   minus;
      logic                   stopped;
      logic                   failed;
   } ad2i_state_type;

endpackage

### rtl/ad2i_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ad2i_core
// Parser state and the per-character update; builds the result beat.
// ----------------------------------------------------------------------------
module ad2i_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  ad2i_pkg::ad2i_req_type beat,
   output ad2i_pkg::ad2i_rsp_type result
);
   import ad2i_pkg::*;

   ad2i_state_type          state_ff;
   ad2i_state_type          state_in;
   ad2i_state_type          stepped;
   logic [WIDE_WIDTH-1:0]   acc_wide;
   logic [WIDE_WIDTH-1:0]   next_wide;
   logic [VALUE_WIDTH-1:0]  next_val;
   logic [VALUE_WIDTH-1:0]  neg_val;
   logic [3:0]              digit;
   logic                    is_digit;
   logic                    overflow;
   logic                    neg_too_big;
   logic                    ok;

   assign digit     = 4'(beat.ch - CHAR_ZERO);
   assign is_digit  = (beat.ch >= CHAR_ZERO) && (beat.ch <= CHAR_NINE);
   assign acc_wide  = WIDE_WIDTH'(state_ff.acc);
   // x*10 + d as two shifts and two adds
   assign next_wide = (acc_wide << 3) + (acc_wide << 1) + WIDE_WIDTH'(digit);
   assign next_val  = next_wide[VALUE_WIDTH-1:0];
   assign overflow  = |next_wide[WIDE_WIDTH-1:VALUE_WIDTH];
   // above 2^(W-1): top bit set with anything below it
   assign neg_too_big = state_ff.minus && next_val[VALUE_WIDTH-1]
                        && (|next_val[VALUE_WIDTH-2:0]);

   always_comb begin
      stepped = state_ff;
      if (!(state_ff.stopped || state_ff.failed)) begin
         if (beat.ch == CHAR_SPACE) begin
            if (state_ff.started) begin
               stepped.stopped = 1'b1;
            end
         end else if (beat.ch == CHAR_MINUS) begin
            stepped.minus = 1'b1;
         end else if (is_digit) begin
            if (overflow || neg_too_big) begin
               stepped.failed = 1'b1;
            end else begin
               stepped.acc     = next_val;
               stepped.started = 1'b1;
            end
         end else begin
            stepped.failed = 1'b1;
         end
      end
   end

   assign state_in = beat.last ? '0 : stepped;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   assign ok = stepped.started && !stepped.failed;

   // two's complement kept within the magnitude width
   assign neg_val = (~stepped.acc) + VALUE_WIDTH'(1);

   always_comb begin
      result.is_negative = stepped.minus;
      result.ok          = ok;
      if (ok && stepped.minus) begin
         result.value = 64'(neg_val);
      end else begin
         result.value = 64'(stepped.acc);
      end
   end

endmodule

### rtl/ascii_decimal_to_int64.sv
`timescale 1ns / 1ps
// A string's result beat is registered in the result stage when its last character
// retires. Throughput: one character per cycle while no held result stalls a last one;
// the x*10 + d step and range check are combinational; a new string may follow at once.
// A held result stalls the input only when the next last character is ready to retire.
// Reset (synchronous, active high) clears parser state and both valid flags.
// ----------------------------------------------------------------------------
// ascii_decimal_to_int64
// Streaming decimal string to 64-bit integer converter, one character per beat.
// ----------------------------------------------------------------------------
module ascii_decimal_to_int64 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ad2i_pkg::ad2i_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ad2i_pkg::ad2i_rsp_type rsp_data
);
   import ad2i_pkg::*;

   // input stage
   logic         in_valid_ff;
   logic         in_valid_in;
   ad2i_req_type in_data_ff;

   // result stage
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   ad2i_rsp_type rsp_data_ff;

   ad2i_rsp_type result;
   logic         out_free;
   logic         fire;
   logic         req_take;

   // A non-last character always retires; a last one needs the result slot.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && (!in_data_ff.last || out_free);
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
   end

   ad2i_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .beat   (in_data_ff),
      .result (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire && in_data_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_data_ff.last) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### test/ascii_decimal_to_int64_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_to_int64_tb
// Self-checking bench for the streaming decimal string converter. Strings are
// fed one character per beat with random gaps; a parser model in the bench
// predicts each string's result beat, and every result beat is compared
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ascii_decimal_to_int64_tb;

   import ad2i_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int CHAR_TARGET = 1100;

   // Largest legal magnitude and the largest magnitude a negative number may have.
   localparam logic [63:0] MAX_MAG = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH);
   localparam logic [63:0] NEG_MAG = 64'd1 << (VALUE_WIDTH - 1);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   ad2i_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   ad2i_rsp_type rsp_data;

   // Parser model state: magnitude so far plus the four status flags.
   logic [VALUE_WIDTH-1:0] model_mag = '0;
   logic                   model_started = 1'b0;
   logic                   model_minus = 1'b0;
   logic                   model_stopped = 1'b0;
   logic                   model_failed = 1'b0;

   ad2i_rsp_type predicted_conversions[$];
   logic [7:0]   line_buf[$];

   int error_count = 0;
   int cycle_count = 0;
   int chars_sent = 0;
   int req_gap_max = 7;
   int rsp_gap_max = 7;
   int rsp_wait_left = 0;   // per-beat stall drawn after each result beat
   int hold_request = 0;    // long receiver hold-off, handed to the receiver
   int hold_left = 0;

   ascii_decimal_to_int64 i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Parser model. Called once per accepted character beat; on the last
   // character it pushes the predicted result and clears its state.
   // --------------------------------------------------------------------------
   task automatic convert_char(input logic [7:0] c, input logic is_last);
      logic [VALUE_WIDTH+3:0] next_mag;
      logic [63:0]            result_value;
      logic                   good;
      ad2i_rsp_type           prediction;

      // Once stopped by a trailing space or failed, the rest of the string is dead.
      if (!(model_stopped || model_failed)) begin
         if (c == CHAR_SPACE) begin
            // Leading spaces are skipped; a space after digits ends the number.
            if (model_started)
               model_stopped = 1'b1;
         end else if (c == CHAR_MINUS) begin
            model_minus = 1'b1;
         end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            // Wide product, so the range test is exact rather than a wrapped compare.
            next_mag = {4'b0000, model_mag} * 10 + (c - CHAR_ZERO);
            if (next_mag > MAX_MAG)
               model_failed = 1'b1;
            else if (model_minus && next_mag > NEG_MAG)
               model_failed = 1'b1;   // negative magnitude out of range
            else begin
               model_mag     = next_mag[VALUE_WIDTH-1:0];
               model_started = 1'b1;
            end
         end else begin
            model_failed = 1'b1;
         end
      end

      if (is_last) begin
         good         = model_started && !model_failed;
         result_value = '0;
         // A minus after the digits is not range checked; the negation just wraps.
         result_value[VALUE_WIDTH-1:0] = (good && model_minus) ? ~model_mag + 1'b1
                                                               : model_mag;
         prediction.value       = result_value;
         prediction.is_negative = model_minus;
         prediction.ok          = good;
         predicted_conversions.push_back(prediction);
         model_mag     = '0;
         model_started = 1'b0;
         model_minus   = 1'b0;
         model_stopped = 1'b0;
         model_failed  = 1'b0;
      end
   endtask

   // --------------------------------------------------------------------------
   // Sender: one character beat. Entered and left at a falling edge; valid is
   // only lowered when a gap is drawn, so back-to-back beats keep it high.
   // --------------------------------------------------------------------------
   task automatic send_char(input logic [7:0] c, input logic is_last);
      int gap;

      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data.ch   <= c;
      req_data.last <= is_last;
      do
         @(posedge clock);
      while (!req_ready);
      convert_char(c, is_last);
      chars_sent++;
      @(negedge clock);
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++)
         line_buf.push_back(s[i]);
   endfunction

   // Sends the buffered string with the last flag on its final character.
   task automatic send_line();
      for (int i = 0; i < line_buf.size(); i++)
         send_char(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // --------------------------------------------------------------------------
   // Receiver. The ready pattern is decided at the falling edge; a long
   // hold-off, when requested, takes priority over the per-beat stall.
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_wait_left > 0) begin
         rsp_wait_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Result checker: each accepted beat against the oldest prediction.
   always @(posedge clock) begin
      ad2i_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait_left = $urandom_range(0, rsp_gap_max);
         if (predicted_conversions.size() == 0) begin
            error_count++;
            $error("result beat with no string pending: value %h neg %b ok %b",
                   rsp_data.value, rsp_data.is_negative, rsp_data.ok);
         end else begin
            want = predicted_conversions.pop_front();
            if (rsp_data.value !== want.value) begin
               error_count++;
               $error("value: expected %h, got %h", want.value, rsp_data.value);
            end
            if (rsp_data.is_negative !== want.is_negative) begin
               error_count++;
               $error("is_negative: expected %b, got %b",
                      want.is_negative, rsp_data.is_negative);
            end
            if (rsp_data.ok !== want.ok) begin
               error_count++;
               $error("ok: expected %b, got %b", want.ok, rsp_data.ok);
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Tests
   // --------------------------------------------------------------------------

   // Range edges, stop and ignore rules, bad characters and the no-digit cases.
   task automatic test_directed();
      add_text("0");                                         send_line();
      add_text($sformatf("%0d", MAX_MAG));                   send_line();
      // One past the largest magnitude: unsigned overflow.
      add_text($sformatf("%0d%0d", MAX_MAG / 10, MAX_MAG % 10 + 1));  send_line();
      add_text($sformatf("-%0d", NEG_MAG));                  send_line();
      // One past the negative limit.
      add_text($sformatf("-%0d%0d", NEG_MAG / 10, NEG_MAG % 10 + 1));  send_line();
      add_text("  42 x-9");                                  send_line();
      add_text("12a3");                                      send_line();
      add_text("--7");                                       send_line();
      add_text("5-");                                        send_line();
      // Minus after a full-range magnitude: no recheck, negation wraps.
      add_text($sformatf("%0d-", MAX_MAG));                  send_line();
      add_text(" ");                                         send_line();
      add_text("-");                                         send_line();
      add_text(" -3");                                       send_line();
      add_text("007");                                       send_line();
      add_text("-0");                                        send_line();
      line_buf.push_back(8'hFF);                             send_line();
      line_buf.push_back(8'h00);                             send_line();
   endtask

   // Mostly well-formed numbers with random content, plus noise strings.
   // Stretches with random gaps alternate with runs where neither side stalls.
   task automatic test_random();
      int          kind;
      int          next_toggle;
      logic [63:0] v;

      next_toggle = chars_sent + 150;
      while (chars_sent < CHAR_TARGET) begin
         if (chars_sent >= next_toggle) begin
            req_gap_max = (req_gap_max == 0) ? 7 : 0;
            rsp_gap_max = (rsp_gap_max == 0) ? 7 : 0;
            next_toggle = chars_sent + 150;
         end
         kind = $urandom_range(0, 9);
         if (kind < 7) begin
            repeat ($urandom_range(0, 2)) add_text(" ");
            if (kind == 3 || $urandom_range(0, 2) == 0)
               add_text(($urandom_range(0, 4) == 0) ? "--" : "-");
            case (kind)
               0, 6: add_text($sformatf("%0d", $urandom_range(0, 99999)));
               1: begin
                  v = {$urandom, $urandom} & MAX_MAG;
                  v = v >> $urandom_range(0, VALUE_WIDTH - 1);
                  add_text($sformatf("%0d", v));
               end
               2: add_text($sformatf("%0d%0d", MAX_MAG / 10, $urandom_range(0, 9)));
               3: add_text($sformatf("%0d%0d", NEG_MAG / 10, $urandom_range(0, 9)));
               default: add_text($sformatf("00%0d", $urandom_range(0, 999)));
            endcase
            case ($urandom_range(0, 5))
               0: begin
                  add_text(" ");
                  repeat ($urandom_range(1, 3))
                     line_buf.push_back(8'($urandom_range(0, 255)));
               end
               1: add_text("-");
               2: line_buf.push_back(8'($urandom_range(0, 255)));
               3: add_text(" ");
               default: ;
            endcase
         end else begin
            // Noise: short strings biased toward the characters the parser cares about.
            repeat ($urandom_range(1, 6)) begin
               case ($urandom_range(0, 3))
                  0: add_text(" ");
                  1: add_text("-");
                  2: line_buf.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
                  default: line_buf.push_back(8'($urandom_range(0, 255)));
               endcase
            end
         end
         send_line();
      end
      req_gap_max = 7;
      rsp_gap_max = 7;
   endtask

   // Receiver holds off for a long stretch while short strings stream in
   // back to back, so the result path fills and the input stalls.
   task automatic test_backpressure();
      req_gap_max  = 0;
      hold_request = 300;
      repeat (40) begin
         add_text($sformatf("%0d", $urandom_range(0, 999)));
         send_line();
      end
      req_gap_max = 7;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_backpressure();
      test_random();

      // Sender ends at a falling edge with no pending assignment to valid.
      req_valid <= 1'b0;
      while (predicted_conversions.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

### ascii_decimal_to_int64.f
rtl/ad2i_pkg.sv
rtl/ad2i_core.sv
rtl/ascii_decimal_to_int64.sv
test/ascii_decimal_to_int64_tb.sv
